@@ rtl/rbf_pkg.sv @@
package rbf_pkg;

    localparam int CH_W           = 8;
    localparam int PIX_W          = 3 * CH_W;
    localparam int LW_W           = 11;
    localparam int COLX_W         = 10;
    localparam int ROW_W          = 12;
    localparam int MIN_WIDTH      = 3;
    localparam int LINE_DEPTH_DEF = 1024;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd640;
    localparam logic [PIX_W-1:0] KEY_COLOR_RST  = 24'hFEFEFE;
    localparam logic             KEY_ENABLE_RST = 1'b1;
    localparam logic [ROW_W-1:0] ROW_MAX        = 12'd4095;

    // Sum of three channel values, then of three column sums.
    localparam int COL_SUM_W = CH_W + 2;
    localparam int TOT_W     = CH_W + 4;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255.
    localparam int               RECIP_W     = 13;
    localparam int               RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP9    = 13'd7282;
    localparam int               PROD_W      = TOT_W + RECIP_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH = 2'd0,
        REG_KEY_COLOR  = 2'd1,
        REG_KEY_ENABLE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    // One new window column: current pixel and the two pixels above it.
    typedef struct packed {
        pix_t pix;
        pix_t p1;
        pix_t p2;
    } col_t;

    typedef struct packed {
        logic              interior;
        logic [COLX_W-1:0] col_x;
        logic [ROW_W-1:0]  row_y;
    } coord_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_y;
        logic [COLX_W-1:0] col_x;
        logic [CH_W-1:0]   avg_blue;
        logic [CH_W-1:0]   avg_green;
        logic [CH_W-1:0]   avg_red;
    } res_t;

endpackage

@@ rtl/rbf_line_store.sv @@
module rbf_line_store #(
    parameter int LINE_DEPTH = rbf_pkg::LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          rd_valid,
    input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    input  rbf_pkg::pix_t                 rd_pix,
    input  logic                          wr_valid,
    output rbf_pkg::col_t                 cols
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int EW  = 2 * rbf_pkg::PIX_W;

    // Each entry holds the pixel of the row above and the one two rows above.
    logic [EW-1:0]  line_mem [LINE_DEPTH];
    logic [EW-1:0]  q_reg;
    logic [AW-1:0]  addr_reg;
    rbf_pkg::pix_t  pix_reg;
    rbf_pkg::pix_t  fwd_pix_reg;
    rbf_pkg::pix_t  fwd_p1_reg;
    logic           fwd_reg;
    rbf_pkg::pix_t  p1;
    rbf_pkg::pix_t  p2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr_valid)
            begin
                line_mem[addr_reg] <= {pix_reg, p1};
            end
            if (rd_valid)
            begin
                q_reg <= line_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && rd_valid)
        begin
            addr_reg    <= rd_addr;
            pix_reg     <= rd_pix;
            fwd_pix_reg <= pix_reg;
            fwd_p1_reg  <= p1;
        end
    end

    // A read at the address being written in the same cycle sees old data,
    // so the item leaving this stage hands its values on directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (en && rd_valid)
        begin
            fwd_reg <= wr_valid && (addr_reg == rd_addr);
        end
    end

    assign p1 = fwd_reg ? fwd_pix_reg : rbf_pkg::pix_t'(q_reg[EW-1:rbf_pkg::PIX_W]);
    assign p2 = fwd_reg ? fwd_p1_reg  : rbf_pkg::pix_t'(q_reg[rbf_pkg::PIX_W-1:0]);

    assign cols.pix = pix_reg;
    assign cols.p1  = p1;
    assign cols.p2  = p2;

endmodule

@@ rtl/rbf_mean.sv @@
module rbf_mean (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rbf_pkg::coord_t             coord,
    input  rbf_pkg::col_t               cols,
    input  logic [rbf_pkg::PIX_W-1:0]   key_color,
    input  logic                        key_enable,
    output logic                        out_valid,
    output rbf_pkg::res_t               out_res
);

    localparam int CH_W  = rbf_pkg::CH_W;
    localparam int CS_W  = rbf_pkg::COL_SUM_W;
    localparam int TOT_W = rbf_pkg::TOT_W;

    logic [rbf_pkg::PIX_W-1:0]  pix_v;
    logic [rbf_pkg::PIX_W-1:0]  p1_v;
    logic [rbf_pkg::PIX_W-1:0]  p2_v;
    logic [rbf_pkg::PIX_W-1:0]  mid_reg;
    logic                       emit;
    logic                       s2_valid_reg;
    logic                       s3_valid_reg;
    logic [rbf_pkg::COLX_W-1:0] s2_col_x_reg;
    logic [rbf_pkg::ROW_W-1:0]  s2_row_y_reg;
    logic [rbf_pkg::COLX_W-1:0] s3_col_x_reg;
    logic [rbf_pkg::ROW_W-1:0]  s3_row_y_reg;
    logic [CH_W-1:0]            avg [3];

    assign pix_v = cols.pix;
    assign p1_v  = cols.p1;
    assign p2_v  = cols.p2;

    // The centre of the window is the middle-row pixel of the previous item.
    assign emit = in_valid && coord.interior && !(key_enable && (mid_reg == key_color));

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_ch
        logic [CS_W-1:0]                  new_sum;
        logic [CS_W-1:0]                  cs_reg [3];
        logic [TOT_W-1:0]                 tot_reg;
        logic [rbf_pkg::PROD_W-1:0]       prod;

        assign new_sum = CS_W'(pix_v[ch*CH_W +: CH_W]) + CS_W'(p1_v[ch*CH_W +: CH_W])
                       + CS_W'(p2_v[ch*CH_W +: CH_W]);

        always_ff @(posedge clk)
        begin
            if (en && in_valid)
            begin
                cs_reg[0] <= cs_reg[1];
                cs_reg[1] <= cs_reg[2];
                cs_reg[2] <= new_sum;
            end
            if (en)
            begin
                tot_reg <= TOT_W'(cs_reg[0]) + TOT_W'(cs_reg[1]) + TOT_W'(cs_reg[2]);
            end
        end

        assign prod    = rbf_pkg::PROD_W'(tot_reg) * rbf_pkg::PROD_W'(rbf_pkg::RECIP9);
        assign avg[ch] = prod[rbf_pkg::RECIP_SHIFT +: CH_W];
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            mid_reg <= p1_v;
        end
        if (en)
        begin
            s2_col_x_reg <= coord.col_x;
            s2_row_y_reg <= coord.row_y;
            s3_col_x_reg <= s2_col_x_reg;
            s3_row_y_reg <= s2_row_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid         = s3_valid_reg;
    assign out_res.avg_red   = avg[2];
    assign out_res.avg_green = avg[1];
    assign out_res.avg_blue  = avg[0];
    assign out_res.col_x     = s3_col_x_reg;
    assign out_res.row_y     = s3_row_y_reg;

endmodule

@@ rtl/rbf_out_skid.sv @@
module rbf_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rbf_pkg::res_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rbf_pkg::res_t  out_data
);

    logic          main_valid_reg;
    logic          skid_valid_reg;
    rbf_pkg::res_t main_reg;
    rbf_pkg::res_t skid_reg;
    logic          push;
    logic          take;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign take     = main_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
            begin
                skid_reg <= in_data;
            end
            else
            begin
                main_reg <= in_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

@@ rtl/rgb_box_filter_3x3.sv @@
// Accepts one pixel item per clock cycle when the output side keeps up.
// An accepted item passes, in order, the line store read register, the column sum register
// and the total register; the reciprocal product then feeds the output register.
// The single read and write per cycle on the line store sets the one-item-per-cycle rate.
// Reset clears the counters, pipeline valids and registers (to their defaults);
// the line store is not cleared and no clearing pass runs, so items are taken at once.
module rgb_box_filter_3x3 #(
    parameter int LINE_DEPTH = rbf_pkg::LINE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rbf_pkg::IN_DATA_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    input  logic                             s_tuser,   // frame_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rbf_pkg::OUT_DATA_W-1:0]   m_tdata,   // avg_red, avg_green, avg_blue,
                                                        // col_x, row_y, zero padding
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rbf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rbf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int CW    = $clog2(LINE_DEPTH);
    localparam int LW_W  = rbf_pkg::LW_W;
    localparam int WW    = (LW_W > CW + 1) ? LW_W : CW + 1;
    localparam int RES_W = $bits(rbf_pkg::res_t);

    logic [LW_W-1:0]           line_width_reg;
    logic [rbf_pkg::PIX_W-1:0] key_color_reg;
    logic                      key_enable_reg;
    logic                      cfg_wr;

    logic [CW-1:0]             col_reg;
    logic [CW-1:0]             col_next;
    logic [CW-1:0]             col_cur;
    logic [rbf_pkg::ROW_W-1:0] row_reg;
    logic [rbf_pkg::ROW_W-1:0] row_next;
    logic [rbf_pkg::ROW_W-1:0] row_cur;
    logic [WW-1:0]             lw_ext;
    logic [WW-1:0]             eff_width;
    logic [WW-1:0]             col_inc;

    logic                      en;
    logic                      accept;
    logic                      s1_valid_reg;
    rbf_pkg::coord_t           s1_coord_reg;
    rbf_pkg::coord_t           coord_cur;
    rbf_pkg::pix_t             in_pix;
    rbf_pkg::col_t             cols;
    logic                      mean_valid;
    rbf_pkg::res_t             mean_res;
    rbf_pkg::res_t             m_res;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= rbf_pkg::LINE_WIDTH_RST;
            key_color_reg  <= rbf_pkg::KEY_COLOR_RST;
            key_enable_reg <= rbf_pkg::KEY_ENABLE_RST;
        end
        else if (cfg_wr)
        begin
            case (rbf_pkg::reg_idx_t'(paddr[3:2]))
                rbf_pkg::REG_LINE_WIDTH: line_width_reg <= pwdata[LW_W-1:0];
                rbf_pkg::REG_KEY_COLOR:  key_color_reg  <= pwdata[rbf_pkg::PIX_W-1:0];
                rbf_pkg::REG_KEY_ENABLE: key_enable_reg <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (rbf_pkg::reg_idx_t'(paddr[3:2]))
            rbf_pkg::REG_LINE_WIDTH: prdata = rbf_pkg::APB_DATA_W'(line_width_reg);
            rbf_pkg::REG_KEY_COLOR:  prdata = rbf_pkg::APB_DATA_W'(key_color_reg);
            rbf_pkg::REG_KEY_ENABLE: prdata = rbf_pkg::APB_DATA_W'(key_enable_reg);
            default:                 prdata = '0;
        endcase
    end

    // Raster position of the incoming item.
    assign en       = s_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_pix   = rbf_pkg::pix_t'({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
    assign col_cur  = s_tuser ? '0 : col_reg;
    assign row_cur  = s_tuser ? '0 : row_reg;
    assign lw_ext   = WW'(line_width_reg);
    assign col_inc  = WW'(col_cur) + WW'(1);

    always_comb
    begin
        if (lw_ext < WW'(rbf_pkg::MIN_WIDTH))
        begin
            eff_width = WW'(rbf_pkg::MIN_WIDTH);
        end
        else if (lw_ext > WW'(LINE_DEPTH))
        begin
            eff_width = WW'(LINE_DEPTH);
        end
        else
        begin
            eff_width = lw_ext;
        end

        if (col_inc >= eff_width)
        begin
            col_next = '0;
            row_next = (row_cur < rbf_pkg::ROW_MAX) ? row_cur + rbf_pkg::ROW_W'(1) : row_cur;
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end

        coord_cur.interior = (col_cur >= CW'(2)) && (row_cur >= rbf_pkg::ROW_W'(2));
        coord_cur.col_x    = rbf_pkg::COLX_W'(col_cur - CW'(1));
        coord_cur.row_y    = row_cur - rbf_pkg::ROW_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_coord_reg <= coord_cur;
        end
    end

    rbf_line_store #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rd_valid (accept),
        .rd_addr  (col_cur),
        .rd_pix   (in_pix),
        .wr_valid (s1_valid_reg),
        .cols     (cols)
    );

    rbf_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s1_valid_reg),
        .coord      (s1_coord_reg),
        .cols       (cols),
        .key_color  (key_color_reg),
        .key_enable (key_enable_reg),
        .out_valid  (mean_valid),
        .out_res    (mean_res)
    );

    rbf_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mean_valid),
        .in_ready  (s_tready),
        .in_data   (mean_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tdata = {{(rbf_pkg::OUT_DATA_W - RES_W){1'b0}}, m_res};

endmodule
